/* sv/half_float_convert_unit_assert.svh */
// Assertion macros used by the checker file of the half float converter.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef HALF_FLOAT_CONVERT_UNIT_ASSERT_SVH
`define HALF_FLOAT_CONVERT_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define HFC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define HFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/hfc_pkg.sv */
// Shared types, codes and conversion functions of the half float converter.
// Depends on nothing; imported by the datapath, the top level and the testbench.
package hfc_pkg;

   localparam logic [1:0] FUNC_S2H = 2'd0;
   localparam logic [1:0] FUNC_H2S = 2'd1;
   localparam logic [1:0] FUNC_CMP = 2'd2;

   // Input word, from the request port.
   typedef struct packed {
      logic [15:0] operand_b;
      logic [31:0] operand_a;
      logic [1:0]  func;
   } req_type;

   // Result word toward the response port.
   typedef struct packed {
      logic              is_negative;
      logic              is_zero_value;
      logic              is_subnormal;
      logic              is_infinite;
      logic              is_nan;
      logic signed [16:0] compare_diff;
      logic [31:0]       converted;
   } rsp_type;

   // Single precision to half precision, truncating.
   function automatic logic [15:0] single_to_half(input logic [31:0] n);
      logic        sgn;
      logic [7:0]  e;
      logic [22:0] f;
      logic [23:0] m;
      logic [3:0]  sh;
      logic [15:0] h;
      sgn = n[31];
      e   = n[30:23];
      f   = n[22:0];
      m   = {1'b1, f};
      sh  = 4'(8'd113 - e);
      if (e >= 8'd143) begin
         if (e == 8'hff && f != '0) begin
            h = {sgn, 5'h1f, (f[22:13] == '0) ? 10'd1 : f[22:13]};
         end else begin
            h = {sgn, 5'h1f, 10'd0};
         end
      end else if (e <= 8'd112) begin
         if (e < 8'd102) begin
            h = {sgn, 15'd0};
         end else begin
            m = m >> sh;
            h = {sgn, 5'd0, m[22:13]};
         end
      end else begin
         h = {sgn, 5'(e - 8'd112), f[22:13]};
      end
      return h;
   endfunction

   // Half precision to single precision, normalizing subnormals.
   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic [4:0]  e;
      logic [9:0]  f;
      logic [7:0]  eo;
      logic [22:0] fo;
      logic [3:0]  lz;
      logic [9:0]  fs;
      e  = h[14:10];
      f  = h[9:0];
      lz = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (f[i]) lz = 4'(9 - i);
      end
      fs = f << (lz + 4'd1);
      if (e == 5'd0) begin
         if (f != '0) begin
            eo = 8'(8'd113 - {4'd0, lz} - 8'd1);
            fo = {fs, 13'd0};
         end else begin
            eo = 8'd0;
            fo = '0;
         end
      end else if (e == 5'h1f) begin
         eo = 8'hff;
         fo = (f != '0) ? {f, 13'h1fff} : 23'd0;
      end else begin
         eo = {3'd0, e} + 8'h70;
         fo = {f, 13'd0};
      end
      return {h[15], eo, fo};
   endfunction

endpackage

/* sv/hfc_datapath.sv */
// Combinational conversion, compare and classification of one word.
// Depends on hfc_pkg.
module hfc_datapath (
   input  hfc_pkg::req_type req,
   output hfc_pkg::rsp_type rsp
);
   import hfc_pkg::*;

   logic [15:0]        h_s2h;
   logic [15:0]        h_cls;
   logic signed [16:0] mag_a;
   logic signed [16:0] mag_b;

   assign h_s2h = single_to_half(req.operand_a);
   assign mag_a = req.operand_a[15] ? -$signed({2'b0, req.operand_a[14:0]})
                                    : $signed({2'b0, req.operand_a[14:0]});
   assign mag_b = req.operand_b[15] ? -$signed({2'b0, req.operand_b[14:0]})
                                    : $signed({2'b0, req.operand_b[14:0]});
   assign h_cls = (req.func == FUNC_S2H) ? h_s2h : req.operand_a[15:0];

   // Select the result by function code; an unused code yields all zeros.
   always_comb begin
      rsp = '0;
      if (req.func == FUNC_S2H || req.func == FUNC_H2S || req.func == FUNC_CMP) begin
         rsp.is_nan        = (h_cls[14:10] == 5'h1f) && (h_cls[9:0] != '0);
         rsp.is_infinite   = (h_cls[14:10] == 5'h1f) && (h_cls[9:0] == '0);
         rsp.is_subnormal  = (h_cls[14:10] == 5'd0) && (h_cls[9:0] != '0);
         rsp.is_zero_value = (h_cls[14:0] == '0);
         rsp.is_negative   = h_cls[15];
      end
      case (req.func)
         FUNC_S2H: rsp.converted    = {16'd0, h_s2h};
         FUNC_H2S: rsp.converted    = half_to_single(req.operand_a[15:0]);
         FUNC_CMP: rsp.compare_diff = mag_a - mag_b;
         default:  rsp.converted    = '0;
      endcase
   end
endmodule

/* sv/half_float_convert_unit.sv */
// Top level of the half float converter: input register, datapath, output register.
// Depends on hfc_pkg and hfc_datapath.
//
// Usage: a request word (func, operand_a, operand_b) enters on the req_
// stream; one response word per request leaves on the rsp_ stream.
// There is one input register, the conversion logic, then an output register
// that drives rsp_tvalid; a request enters the input register when accepted.
// Throughput is one word per cycle while the receiver keeps rsp_tready high,
// set by the single pass through the datapath.
// req_tready stays high while the output register is free or being drained;
// when the receiver stalls, the result holds in the output register and
// the input register holds one more word, after which req_tready drops.
// Reset clears both valid flags; no words are in flight after it.
// func 3 returns a word with every field zero.
module half_float_convert_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] func, [33:2] operand_a, [49:34] operand_b, [55:50] zero
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] converted, [48:32] compare_diff, [49] is_nan, [50] is_infinite,
   // [51] is_subnormal, [52] is_zero_value, [53] is_negative, [55:54] zero
   output logic [55:0] rsp_tdata
);
   import hfc_pkg::*;

   logic    in_vld_ff, in_vld_in;
   req_type in_ff, in_in;
   logic    out_vld_ff, out_vld_in;
   rsp_type out_ff, out_in;
   rsp_type dp_rsp;
   logic    out_free;
   logic    move;

   hfc_datapath u_dp (.req(in_ff), .rsp(dp_rsp));

   // Handshake: the stage advances when the output register can take a word.
   assign out_free   = !out_vld_ff || rsp_tready;
   assign move       = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || out_free;
   assign in_vld_in  = (req_tvalid && req_tready) || (in_vld_ff && !out_free);
   assign in_in      = (req_tvalid && req_tready) ? req_type'(req_tdata[49:0]) : in_ff;
   assign out_vld_in = move || (out_vld_ff && !rsp_tready);
   assign out_in     = move ? dp_rsp : out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {2'b0, out_ff};
endmodule

/* sv/hfc_checker.sv */
// Port-level checker of the half float converter, bound to the top level.
// Depends on half_float_convert_unit_assert.svh.
`include "half_float_convert_unit_assert.svh"
module hfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);
   `HFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled word changed")
   `HFC_ASSERT_IMPL(a_flags_onehot, clock, reset, rsp_tvalid, $countones(rsp_tdata[52:49]) <= 1, "conflicting class flags")
   `HFC_ASSERT_IMPL(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[55:54] == 2'b0, "padding not zero")
   `HFC_ASSERT_IMPL(a_ready_free, clock, reset, !rsp_tvalid, req_tready, "not ready with empty output")
   `HFC_ASSERT_NEXT(a_rsp_follows, clock, reset, req_tvalid && req_tready, ##1 rsp_tvalid, "no response after request")
endmodule

bind half_float_convert_unit hfc_checker u_hfc_checker (.*);

/* tb/sv/tb.sv */
// Self-checking testbench of half_float_convert_unit: a directed table, then random words.
// Depends on hfc_pkg and the RTL of half_float_convert_unit; needs no files or arguments.
`timescale 1ns / 100ps

module tb;
   import hfc_pkg::*;

   typedef struct packed {
      logic               is_negative;
      logic               is_zero_value;
      logic               is_subnormal;
      logic               is_infinite;
      logic               is_nan;
      logic signed [16:0] compare_diff;
      logic [31:0]        converted;
   } result_type;

   typedef struct {
      logic [1:0]  func;
      logic [31:0] op_a;
      logic [15:0] op_b;
      bit          typed;
      result_type  want;
   } stim_row_type;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;

   result_type pending_results[$];
   int         send_idle_pct;
   int         recv_idle_pct;
   int         error_count;
   int         words_checked;

   half_float_convert_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // Free-running clock, 20 ns period.
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Classification flags of one half-precision pattern.
   function automatic result_type classify_half(input logic [15:0] h, input result_type r);
      r.is_nan        = (h[14:10] == 5'h1f) && (h[9:0] != 0);
      r.is_infinite   = (h[14:10] == 5'h1f) && (h[9:0] == 0);
      r.is_subnormal  = (h[14:10] == 5'h00) && (h[9:0] != 0);
      r.is_zero_value = (h[14:0] == 0);
      r.is_negative   = h[15];
      return r;
   endfunction

   // Binary32 to binary16, truncating toward zero.
   function automatic logic [15:0] narrow_to_half(input logic [31:0] n);
      logic [15:0] sgn;
      logic [31:0] expo;
      logic [31:0] frac;
      sgn  = {n[31], 15'd0};
      expo = n & 32'h7f800000;
      frac = n & 32'h007fffff;
      if (expo >= 32'h47800000) begin
         if (expo == 32'h7f800000 && frac != 0) begin
            frac = frac >> 13;
            if (frac == 0) frac = 1;
            return sgn | 16'h7c00 | frac[15:0];
         end
         return sgn | 16'h7c00;
      end
      if (expo <= 32'h38000000) begin
         if (expo < 32'h33000000) return sgn;
         frac = (frac | 32'h00800000) >> (113 - (expo >> 23));
         return sgn | frac[28:13];
      end
      expo = (expo - 32'h38000000) >> 13;
      return sgn | expo[15:0] | frac[28:13];
   endfunction

   // Binary16 to binary32, normalizing subnormals.
   function automatic logic [31:0] widen_to_single(input logic [15:0] h);
      logic [7:0]  expo;
      logic [10:0] frac;
      logic [22:0] frac_out;
      expo = {3'd0, h[14:10]};
      frac = {1'b0, h[9:0]};
      frac_out = {h[9:0], 13'd0};
      if (h[14:10] == 0) begin
         if (h[9:0] == 0) begin
            frac_out = '0;
         end else begin
            expo = 8'h70;
            frac = frac << 1;
            while (!frac[10]) begin
               frac = frac << 1;
               expo = expo - 8'd1;
            end
            frac_out = {frac[9:0], 13'd0};
         end
      end else if (h[14:10] == 5'h1f) begin
         expo = 8'hff;
         frac_out = (h[9:0] != 0) ? {h[9:0], 13'h1fff} : 23'd0;
      end else begin
         expo = expo + 8'h70;
      end
      return {h[15], expo, frac_out};
   endfunction

   function automatic logic signed [16:0] signed_mag(input logic [15:0] h);
      logic signed [16:0] v;
      v = {2'b00, h[14:0]};
      return h[15] ? -v : v;
   endfunction

   // Expected response word for one request word.
   function automatic result_type convert_expected(input logic [1:0] func,
                                                   input logic [31:0] a,
                                                   input logic [15:0] b);
      result_type r;
      logic [15:0] h;
      r = '0;
      case (func)
         FUNC_S2H: begin
            h = narrow_to_half(a);
            r.converted = {16'd0, h};
            r = classify_half(h, r);
         end
         FUNC_H2S: begin
            r.converted = widen_to_single(a[15:0]);
            r = classify_half(a[15:0], r);
         end
         FUNC_CMP: begin
            r.compare_diff = signed_mag(a[15:0]) - signed_mag(b);
            r = classify_half(a[15:0], r);
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   // Drive one word and wait for its acceptance.
   task automatic send_word(input logic [1:0] func, input logic [31:0] a,
                            input logic [15:0] b, input bit typed, input result_type want);
      result_type model;
      // Idle cycles before this word keep valid low.
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, b, a, func};
      model = convert_expected(func, a, b);
      if (typed && model !== want) begin
         $display("%0t: table row mismatch func=%0d a=%h expected %h model %h",
                  $time, func, a, want, model);
         error_count++;
      end
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(typed ? want : model);
   endtask

   // Receiver readiness and response checking.
   always @(posedge clock) begin
      result_type got;
      result_type exp_r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[53:0];
            words_checked++;
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected response %h", $time, got);
               error_count++;
            end else begin
               exp_r = pending_results.pop_front();
               if (got.converted !== exp_r.converted)
                  $display("%0t: converted expected %h actual %h", $time,
                           exp_r.converted, got.converted);
               if (got.compare_diff !== exp_r.compare_diff)
                  $display("%0t: compare_diff expected %0d actual %0d", $time,
                           exp_r.compare_diff, got.compare_diff);
               if (got[53:49] !== exp_r[53:49])
                  $display("%0t: flags expected %b actual %b", $time,
                           exp_r[53:49], got[53:49]);
               if (got !== exp_r) error_count++;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Random operand biased toward interesting exponent bands.
   function automatic logic [31:0] random_single();
      logic [31:0] n;
      n = $urandom();
      case ($urandom_range(5))
         0: n[30:23] = 8'hff;
         1: n[30:23] = 8'($urandom_range(100, 114));
         2: n[30:23] = 8'($urandom_range(140, 145));
         default: ;
      endcase
      return n;
   endfunction

   function automatic logic [15:0] random_half();
      logic [15:0] h;
      h = 16'($urandom());
      case ($urandom_range(4))
         0: h[14:10] = 5'h1f;
         1: h[14:10] = 5'h00;
         default: ;
      endcase
      return h;
   endfunction

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      logic [1:0] f;
      int phase;
      int k;
      int settle;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      error_count  = 0;
      words_checked = 0;
      send_idle_pct = 37;
      recv_idle_pct = 82;

      // Directed table: typed results where they are obvious, else predicted.
      rows = '{
         '{FUNC_S2H, 32'h0000_0000, 16'h0, 1'b1, result_type'({5'b01000, 17'd0, 32'h0})},
         '{FUNC_S2H, 32'h8000_0000, 16'h0, 1'b1, result_type'({5'b11000, 17'd0, 32'h8000})},
         '{FUNC_S2H, 32'h7f80_0000, 16'h0, 1'b1, result_type'({5'b00010, 17'd0, 32'h7c00})},
         '{FUNC_S2H, 32'hff80_0000, 16'h0, 1'b1, result_type'({5'b10010, 17'd0, 32'hfc00})},
         '{FUNC_S2H, 32'h7f80_0001, 16'h0, 1'b1, result_type'({5'b00001, 17'd0, 32'h7c01})},
         '{FUNC_S2H, 32'hffff_ffff, 16'h0, 1'b0, result_type'('0)},
         '{FUNC_S2H, 32'h4780_0000, 16'h0, 1'b0, result_type'('0)},
         '{FUNC_S2H, 32'h477f_ffff, 16'h0, 1'b0, result_type'('0)},
         '{FUNC_S2H, 32'h3880_0000, 16'h0, 1'b0, result_type'('0)},
         '{FUNC_S2H, 32'h3800_0000, 16'h0, 1'b0, result_type'('0)},
         '{FUNC_S2H, 32'h3300_0000, 16'h0, 1'b0, result_type'('0)},
         '{FUNC_S2H, 32'h32ff_ffff, 16'h0, 1'b0, result_type'('0)},
         '{FUNC_S2H, 32'h3f80_1fff, 16'h0, 1'b0, result_type'('0)},
         '{FUNC_H2S, 32'h0000_0000, 16'h0, 1'b1, result_type'({5'b01000, 17'd0, 32'h0})},
         '{FUNC_H2S, 32'hffff_0001, 16'h0, 1'b0, result_type'('0)},
         '{FUNC_H2S, 32'h0000_03ff, 16'h0, 1'b0, result_type'('0)},
         '{FUNC_H2S, 32'h0000_7c00, 16'h0, 1'b1,
           result_type'({5'b00010, 17'd0, 32'h7f80_0000})},
         '{FUNC_H2S, 32'h0000_fe00, 16'h0, 1'b0, result_type'('0)},
         '{FUNC_H2S, 32'h0000_7bff, 16'h0, 1'b0, result_type'('0)},
         '{FUNC_CMP, 32'h0000_8000, 16'h0000, 1'b1,
           result_type'({5'b11000, 17'd0, 32'h0})},
         '{FUNC_CMP, 32'h0000_7fff, 16'hffff, 1'b0, result_type'('0)},
         '{FUNC_CMP, 32'hffff_ffff, 16'h7fff, 1'b0, result_type'('0)},
         '{FUNC_CMP, 32'h0000_3c00, 16'h3c00, 1'b0, result_type'('0)},
         '{FUNC_UNUSED, 32'hffff_ffff, 16'hffff, 1'b1, result_type'('0)}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         row = rows[i];
         send_word(row.func, row.op_a, row.op_b, row.typed, row.want);
      end

      // Three idling phases over the random words.
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 82 : 0;
         recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 37 : 0;
         for (k = 0; k < 160; k++) begin
            f = 2'($urandom_range(3));
            if (f == FUNC_UNUSED && $urandom_range(3) != 0) f = FUNC_CMP;
            send_word(f, (f == FUNC_S2H) ? random_single() : {16'($urandom()), random_half()},
                      random_half(), 1'b0, result_type'('0));
         end
      end
      req_tvalid <= 1'b0;

      settle = 0;
      while (pending_results.size() != 0 && settle < 100000) begin
         @(posedge clock);
         settle++;
      end
      repeat (10) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, pending_results.size());
         error_count++;
      end

      $display("Ran %0d directed and 480 random words through all three functions,",
               rows.size());
      $display("checked %0d responses under three idling patterns.", words_checked);
      if (error_count == 0) begin
         $display("PASS half_float_convert_unit");
      end else begin
         $display("FAIL half_float_convert_unit");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #5_000_000;
      $display("FAIL half_float_convert_unit");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+sv
sv/hfc_pkg.sv
sv/hfc_datapath.sv
sv/half_float_convert_unit.sv
sv/hfc_checker.sv
tb/sv/tb.sv
